// ===== sv/class_aware_nms_engine_unit_assert.svh =====
// Assertion macros used by the suppression engine datapath.
`ifndef CLASS_AWARE_NMS_ENGINE_UNIT_ASSERT_SVH
`define CLASS_AWARE_NMS_ENGINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CANMS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CANMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/canms_pkg.sv =====
// Types, constants and codes shared by the suppression engine modules.
`default_nettype none
package canms_pkg;

  localparam int CAND_DEPTH_DEF = 256;
  localparam int MAX_KEEP_DEF   = 32;

  localparam int SCORE_W  = 16;
  localparam int CLASS_W  = 8;
  localparam int COORD_W  = 12;
  localparam int SIZE_W   = 13;
  localparam int EDGE_W   = 14;
  localparam int AREA_W   = 2 * SIZE_W;
  localparam int INTER_W  = 2 * EDGE_W;
  localparam int UNION_W  = AREA_W + 1;
  localparam int THR_W    = 16;
  localparam int MK_W     = 6;
  localparam int PROD_W   = THR_W + UNION_W;
  localparam int CMPW     = INTER_W + 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEEP  = 1'b1;

  localparam logic [THR_W-1:0] THR_RESET  = 16'd29491;
  localparam logic [MK_W-1:0]  MAXK_RESET = 6'd32;

  localparam int SUP_LAT = 6;
  localparam int WCNT_W  = 3;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [CLASS_W-1:0] class_id;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [SIZE_W-1:0]  box_width;
    logic [SIZE_W-1:0]  box_height;
    logic               last;
  } cand_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [CLASS_W-1:0] class_id;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [SIZE_W-1:0]  box_width;
    logic [SIZE_W-1:0]  box_height;
  } rec_t;

  typedef struct packed {
    logic [SCORE_W-1:0] kept_score;
    logic [CLASS_W-1:0] kept_class;
    logic [COORD_W-1:0] kept_left;
    logic [COORD_W-1:0] kept_top;
    logic [SIZE_W-1:0]  kept_width;
    logic [SIZE_W-1:0]  kept_height;
    logic               final_result;
    logic               overflow;
  } result_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SEL_INIT,
    S_SCAN_INIT,
    S_SCAN,
    S_SCAN_WAIT,
    S_SCAN_END,
    S_CMP,
    S_KEEP,
    S_OUT,
    S_OUT_END
  } state_t;

  typedef struct packed {
    logic load;
    logic sel_init;
    logic scan_init;
    logic scan_step;
    logic scan_end;
    logic cmp_next;
    logic keep;
    logic out_init;
    logic out_step;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic cand_empty;
    logic scan_last;
    logic all_visited;
    logic kept_none;
    logic keep_full_next;
    logic j_last;
    logic suppress;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/canms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module canms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/canms_dp.sv =====
// Datapath: candidate and kept stores, ordering scan, overlap test and result output.
`default_nettype none
module canms_dp #(
  parameter int CAND_DEPTH = canms_pkg::CAND_DEPTH_DEF,
  parameter int MAX_KEEP   = canms_pkg::MAX_KEEP_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [canms_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [canms_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  canms_pkg::cand_t                    cand,
  input  canms_pkg::cmd_t                     cmd,
  output canms_pkg::status_t                  status,
  output logic                                result_valid,
  output canms_pkg::result_t                  result
);
  import canms_pkg::*;
  `include "class_aware_nms_engine_unit_assert.svh"

  localparam int AW   = $clog2(CAND_DEPTH);
  localparam int CW   = $clog2(CAND_DEPTH + 1);
  localparam int KAW  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int LW   = $clog2(MAX_KEEP + 1);
  localparam int KEYW = SCORE_W + AW;

  logic [THR_W-1:0] nms_threshold;
  logic [MK_W-1:0]  max_keep;
  logic [LW-1:0]    limit;

  logic [CW-1:0]    cand_count;
  logic             ovf;
  logic             cand_full;
  rec_t             cand_wrec;
  rec_t             crd;

  logic [CW-1:0]    scan_idx;
  logic             rd_pend;
  logic [AW-1:0]    rd_idx;
  logic [KEYW-1:0]  cur_key;
  logic [KEYW-1:0]  best_key;
  logic [KEYW-1:0]  prev_key;
  rec_t             best_rec;
  logic             best_valid;
  logic             first;
  logic             take;
  logic [CW-1:0]    visited;

  logic [LW-1:0]    kept_count;
  logic [LW-1:0]    j;
  rec_t             kdata;

  logic [COORD_W-1:0] il, it;
  logic [EDGE_W-1:0]  ir, ib, iw, ih;
  logic [AREA_W-1:0]  area_a, area_b;
  logic [INTER_W-1:0] inter3, inter4, inter5;
  logic [UNION_W-1:0] area_sum, uni4;
  logic [PROD_W-1:0]  prod5;
  logic               uni_nz;

  logic out_pend;
  logic out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      nms_threshold <= THR_RESET;
      max_keep      <= MAXK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_THRESHOLD: nms_threshold <= cfg_data;
        CFG_MAX_KEEP:  max_keep      <= cfg_data[MK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (max_keep == '0) begin
      limit = LW'(1);
    end else if ({1'b0, max_keep} > (MK_W + 1)'(MAX_KEEP)) begin
      limit = LW'(MAX_KEEP);
    end else begin
      limit = LW'(max_keep);
    end
  end

  assign cand_full = (cand_count == CW'(CAND_DEPTH));
  assign cand_wrec = '{score: cand.score, class_id: cand.class_id, left: cand.left,
                       top: cand.top, box_width: cand.box_width,
                       box_height: cand.box_height};

  canms_ram #(.WIDTH($bits(rec_t)), .DEPTH(CAND_DEPTH)) u_cand_ram (
    .clk   (clk),
    .we    (cmd.load && !cand_full),
    .waddr (cand_count[AW-1:0]),
    .wdata (cand_wrec),
    .raddr (scan_idx[AW-1:0]),
    .rdata (crd)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cand_count <= '0;
      ovf        <= 1'b0;
    end else if (cmd.load) begin
      if (cand_full) begin
        ovf <= 1'b1;
      end else begin
        cand_count <= cand_count + CW'(1);
      end
    end
  end

  assign cur_key = {crd.score, ~rd_idx};
  assign take = rd_pend && (first || (cur_key < prev_key)) &&
                (!best_valid || (cur_key > best_key));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend    <= 1'b0;
      best_valid <= 1'b0;
      first      <= 1'b1;
      visited    <= '0;
      scan_idx   <= '0;
    end else begin
      rd_pend <= cmd.scan_step;
      if (cmd.scan_step) begin
        rd_idx   <= scan_idx[AW-1:0];
        scan_idx <= scan_idx + CW'(1);
      end
      if (cmd.scan_init) begin
        scan_idx   <= '0;
        best_valid <= 1'b0;
      end else if (take) begin
        best_valid <= 1'b1;
        best_key   <= cur_key;
        best_rec   <= crd;
      end
      if (cmd.sel_init) begin
        first   <= 1'b1;
        visited <= '0;
      end
      if (cmd.scan_end) begin
        prev_key <= best_key;
        first    <= 1'b0;
        visited  <= visited + CW'(1);
      end
    end
  end

  canms_ram #(.WIDTH($bits(rec_t)), .DEPTH(MAX_KEEP)) u_kept_ram (
    .clk   (clk),
    .we    (cmd.keep),
    .waddr (kept_count[KAW-1:0]),
    .wdata (best_rec),
    .raddr (j[KAW-1:0]),
    .rdata (kdata)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.sel_init) begin
      kept_count <= '0;
    end else if (cmd.keep) begin
      kept_count <= kept_count + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0;
    end else if (cmd.scan_end || cmd.out_init) begin
      j <= '0;
    end else if (cmd.cmp_next || cmd.out_step) begin
      j <= j + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    il <= (best_rec.left > kdata.left) ? best_rec.left : kdata.left;
    it <= (best_rec.top > kdata.top) ? best_rec.top : kdata.top;
    ir <= ((EDGE_W'(best_rec.left) + EDGE_W'(best_rec.box_width)) <
           (EDGE_W'(kdata.left) + EDGE_W'(kdata.box_width))) ?
          (EDGE_W'(best_rec.left) + EDGE_W'(best_rec.box_width)) :
          (EDGE_W'(kdata.left) + EDGE_W'(kdata.box_width));
    ib <= ((EDGE_W'(best_rec.top) + EDGE_W'(best_rec.box_height)) <
           (EDGE_W'(kdata.top) + EDGE_W'(kdata.box_height))) ?
          (EDGE_W'(best_rec.top) + EDGE_W'(best_rec.box_height)) :
          (EDGE_W'(kdata.top) + EDGE_W'(kdata.box_height));

    iw     <= (ir > EDGE_W'(il)) ? (ir - EDGE_W'(il)) : '0;
    ih     <= (ib > EDGE_W'(it)) ? (ib - EDGE_W'(it)) : '0;
    area_a <= AREA_W'(best_rec.box_width) * AREA_W'(best_rec.box_height);
    area_b <= AREA_W'(kdata.box_width) * AREA_W'(kdata.box_height);

    inter3   <= INTER_W'(iw) * INTER_W'(ih);
    area_sum <= UNION_W'(area_a) + UNION_W'(area_b);

    uni4   <= area_sum - UNION_W'(inter3);
    inter4 <= inter3;

    prod5  <= PROD_W'(nms_threshold) * PROD_W'(uni4);
    inter5 <= inter4;
    uni_nz <= (uni4 != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_pend <= 1'b0;
      out_last <= 1'b0;
    end else begin
      out_pend <= cmd.out_step;
      if (cmd.out_step) begin
        out_last <= status.j_last;
      end
    end
  end

  assign status.cand_empty     = (cand_count == '0);
  assign status.scan_last      = (scan_idx == (cand_count - CW'(1)));
  assign status.all_visited    = (visited == cand_count);
  assign status.kept_none      = (kept_count == '0);
  assign status.keep_full_next = (LW'(kept_count + LW'(1)) == limit);
  assign status.j_last         = (LW'(j + LW'(1)) == kept_count);
  assign status.suppress       = (kdata.class_id == best_rec.class_id) && uni_nz &&
                                 ({inter5, 16'b0} > CMPW'(prod5));

  assign result_valid        = out_pend;
  assign result.kept_score   = kdata.score;
  assign result.kept_class   = kdata.class_id;
  assign result.kept_left    = kdata.left;
  assign result.kept_top     = kdata.top;
  assign result.kept_width   = kdata.box_width;
  assign result.kept_height  = kdata.box_height;
  assign result.final_result = out_last;
  assign result.overflow     = ovf;

  `CANMS_ASSERT_SAME(a_step_finds_cand, cmd.scan_end, best_valid,
                     "Selection step ended without a candidate.")
  `CANMS_ASSERT_SAME(a_keep_in_limit, cmd.keep, kept_count < limit,
                     "Kept store written beyond the keep limit.")
  `CANMS_ASSERT_SAME(a_result_has_kept, out_pend, kept_count != '0,
                     "Result issued with no kept detection.")
  `CANMS_ASSERT_NEXT(a_final_marked, cmd.out_step && status.j_last,
                     result_valid && result.final_result,
                     "Last kept detection was not marked final.")
endmodule
`default_nettype wire

// ===== sv/canms_ctrl.sv =====
// Controller state machine sequencing load, ordering scan, overlap checks and output.
`default_nettype none
module canms_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               cand_last,
  input  canms_pkg::status_t status,
  output canms_pkg::cmd_t    cmd,
  output logic               busy
);
  import canms_pkg::*;

  state_t state, state_next;
  logic [WCNT_W-1:0] wcnt, wcnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      wcnt  <= '0;
    end else begin
      state <= state_next;
      wcnt  <= wcnt_next;
    end
  end

  always_comb begin
    state_next = state;
    wcnt_next  = wcnt;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      S_LOAD: begin
        busy     = 1'b0;
        cmd.load = start;
        if (start && cand_last) begin
          state_next = S_SEL_INIT;
        end
      end
      S_SEL_INIT: begin
        if (status.cand_empty) begin
          cmd.clear  = 1'b1;
          state_next = S_LOAD;
        end else begin
          cmd.sel_init = 1'b1;
          state_next   = S_SCAN_INIT;
        end
      end
      S_SCAN_INIT: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        state_next = S_SCAN_END;
      end
      S_SCAN_END: begin
        cmd.scan_end = 1'b1;
        wcnt_next    = '0;
        state_next   = status.kept_none ? S_KEEP : S_CMP;
      end
      S_CMP: begin
        if (wcnt == WCNT_W'(SUP_LAT)) begin
          wcnt_next = '0;
          if (status.suppress) begin
            if (status.all_visited) begin
              cmd.out_init = 1'b1;
              state_next   = S_OUT;
            end else begin
              state_next = S_SCAN_INIT;
            end
          end else if (status.j_last) begin
            state_next = S_KEEP;
          end else begin
            cmd.cmp_next = 1'b1;
          end
        end else begin
          wcnt_next = wcnt + WCNT_W'(1);
        end
      end
      S_KEEP: begin
        cmd.keep = 1'b1;
        if (status.keep_full_next || status.all_visited) begin
          cmd.out_init = 1'b1;
          state_next   = S_OUT;
        end else begin
          state_next = S_SCAN_INIT;
        end
      end
      S_OUT: begin
        cmd.out_step = 1'b1;
        if (status.j_last) begin
          state_next = S_OUT_END;
        end
      end
      S_OUT_END: begin
        cmd.clear  = 1'b1;
        state_next = S_LOAD;
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/class_aware_nms_engine_unit.sv =====
// Top level of the class-aware greedy non-maximum suppression engine.
//
// Candidate items are offered on cand with start; an item is taken at a clock
// edge where start is high and busy is low. The item with last set closes the
// set, and busy then stays high while the engine orders, selects and outputs.
// Each selection step scans the whole candidate store through its single read
// port, and comparisons against kept boxes of any class run in the overlap unit.
// Kept detections appear on result, one per cycle, each for exactly one cycle
// with result_valid high; the receiver cannot hold them off. The last one has
// final_result set, and overflow reports candidates dropped for lack of space.
// A set with no stored candidate gives no results. Configuration writes on
// cfg_we, cfg_idx and cfg_data take effect at once; the user is to make them
// only while idle, as the block itself does not enforce this. Reset is
// synchronous and returns the engine to loading with an empty set and the
// default threshold and keep limit.
`default_nettype none
module class_aware_nms_engine_unit #(
  parameter int CAND_DEPTH = canms_pkg::CAND_DEPTH_DEF,
  parameter int MAX_KEEP   = canms_pkg::MAX_KEEP_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  canms_pkg::cand_t                 cand,
  input  logic                             cfg_we,
  input  logic [canms_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [canms_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                             result_valid,
  output canms_pkg::result_t               result
);
  import canms_pkg::*;

  cmd_t    cmd;
  status_t status;

  canms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cand_last (cand.last),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  canms_dp #(.CAND_DEPTH(CAND_DEPTH), .MAX_KEEP(MAX_KEEP)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .cand         (cand),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );
endmodule
`default_nettype wire
